[sv/uqsd_pkg.sv]
// shared constants, types and hex helper for the url query string decoder
package uqsd_pkg;

    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] SEC_PATH  = 2'd0;
    localparam logic [1:0] SEC_KEY   = 2'd1;
    localparam logic [1:0] SEC_VALUE = 2'd2;
    localparam logic [1:0] SEC_FRESH = 2'd3;

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_STRAY = 2'd3;

    localparam logic [1:0] PART_PATH  = 2'd0;
    localparam logic [1:0] PART_KEY   = 2'd1;
    localparam logic [1:0] PART_VALUE = 2'd2;

    typedef struct packed {
        logic [1:0] section;
        logic [1:0] phase;
        logic [3:0] nibble;
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] part;
        logic       pair_end;
        logic       bad_escape;
        logic       uri_end;
    } result_t;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[sv/uqsd_step.sv]
// per-byte section tracking and percent decoding
module uqsd_step
    import uqsd_pkg::*;
(
    input  state_t     cur,
    input  logic [7:0] uri_byte,
    input  logic       is_last,
    output state_t     nxt,
    output result_t    res
);

    logic [1:0] sec;
    logic [1:0] ph;
    logic [3:0] nib;
    logic [4:0] hx;
    logic       delim;

    assign hx    = hex_digit(uri_byte);
    assign delim = uri_byte inside {CH_AMP, CH_SEMI};

    always_comb
    begin
        sec = cur.section;
        ph  = (cur.phase == PH_STRAY) ? PH_NONE : cur.phase;
        nib = cur.nibble;
        res = '0;
        res.uri_end = is_last;
        case (cur.section)
            SEC_PATH:  res.part = PART_PATH;
            SEC_VALUE: res.part = PART_VALUE;
            default:   res.part = PART_KEY;
        endcase

        case (cur.section)
            SEC_PATH:
            begin
                if (uri_byte == CH_QUERY)
                begin
                    sec = SEC_FRESH;
                end
                else
                begin
                    res.out_byte   = uri_byte;
                    res.byte_valid = 1'b1;
                end
            end
            SEC_VALUE:
            begin
                if (delim)
                begin
                    res.bad_escape = (ph != PH_NONE);
                    ph             = PH_NONE;
                    res.pair_end   = 1'b1;
                    sec            = SEC_FRESH;
                end
                else if (ph == PH_HIGH)
                begin
                    if (hx[4])
                    begin
                        nib = hx[3:0];
                        ph  = PH_LOW;
                    end
                    else
                    begin
                        res.bad_escape = 1'b1;
                        ph             = PH_NONE;
                    end
                end
                else if (ph == PH_LOW)
                begin
                    if (hx[4])
                    begin
                        res.out_byte   = {cur.nibble, hx[3:0]};
                        res.byte_valid = 1'b1;
                    end
                    else
                    begin
                        res.bad_escape = 1'b1;
                    end
                    ph = PH_NONE;
                end
                else if (uri_byte == CH_PLUS)
                begin
                    res.out_byte   = CH_SPACE;
                    res.byte_valid = 1'b1;
                end
                else if (uri_byte == CH_PCT)
                begin
                    ph = PH_HIGH;
                end
                else
                begin
                    res.out_byte   = uri_byte;
                    res.byte_valid = 1'b1;
                end
            end
            default:
            begin
                ph = PH_NONE;
                if (delim)
                begin
                    res.pair_end = 1'b1;
                    sec          = SEC_FRESH;
                end
                else if (uri_byte == CH_EQ)
                begin
                    sec = SEC_VALUE;
                end
                else
                begin
                    res.out_byte   = uri_byte;
                    res.byte_valid = 1'b1;
                    sec            = SEC_KEY;
                end
            end
        endcase

        if (is_last)
        begin
            if (ph != PH_NONE)
            begin
                res.bad_escape = 1'b1;
            end
            if (sec == SEC_KEY || sec == SEC_VALUE)
            begin
                res.pair_end = 1'b1;
            end
            sec = SEC_PATH;
            ph  = PH_NONE;
            nib = 4'd0;
        end

        nxt.section = sec;
        nxt.phase   = ph;
        nxt.nibble  = nib;
    end

endmodule

[sv/url_query_string_decoder.sv]
// top level of the url query string decoder
//
// usage: the request URI enters one byte per transfer on the input channel
// (in_valid, in_stall, uri_byte, is_last); is_last marks the final byte.
// every input byte yields exactly one result transfer on the output channel
// (out_valid, out_stall, out_byte, byte_valid, part, pair_end, bad_escape,
// uri_end). bytes before the first '?' come out as path, then keys pass raw
// and values are decoded ('+' to space, '%xx' to a byte).
// a byte taken sits in the input register, is decoded and lands in the
// result register when that register is free or its result is being taken,
// and is offered from there.
// throughput: one byte per cycle while out_stall stays low, set by the single
// decode step between the input register and the result register.
// while out_stall is high and a result is offered, the result register holds;
// the input register then fills and in_stall rises until the result is taken.
// reset clears both registers' valid flags and returns the parse state to
// the path section with no escape pending.
module url_query_string_decoder
    import uqsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] uri_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [1:0] part,
    output logic       pair_end,
    output logic       bad_escape,
    output logic       uri_end
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    uqsd_step u_step (
        .cur      (state_reg),
        .uri_byte (s1_byte_reg),
        .is_last  (s1_last_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= uri_byte;
            s1_last_reg <= is_last;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = res_reg.out_byte;
    assign byte_valid = res_reg.byte_valid;
    assign part       = res_reg.part;
    assign pair_end   = res_reg.pair_end;
    assign bad_escape = res_reg.bad_escape;
    assign uri_end    = res_reg.uri_end;

`ifndef SYNTHESIS
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last_reg |=> state_reg.section == SEC_PATH && state_reg.phase == PH_NONE
                                   && state_reg.nibble == 4'd0)
        else $error("parse state not cleared after final byte");

    a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.byte_valid |-> res_reg.out_byte == 8'd0)
        else $error("out_byte nonzero without data");

    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.part != 2'd3)
        else $error("illegal part code");

    a_bad_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.bad_escape |-> res_reg.part == PART_VALUE)
        else $error("escape error outside a value");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room to move");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the url query string decoder with a built-in byte decode predictor
module tb_top
    import uqsd_pkg::*;
();

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] uri_byte = 8'h00;
    logic       is_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] part;
    logic       pair_end;
    logic       bad_escape;
    logic       uri_end;

    logic [1:0] section_q = SEC_PATH;
    logic [1:0] phase_q = PH_NONE;
    logic [3:0] nibble_q = 4'd0;
    result_t    pending_decodes[$];
    logic [7:0] uri_buf[$];

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int uris_sent = 0;
    int results_checked = 0;
    int bad_escapes_seen = 0;
    int pair_ends_seen = 0;
    int input_stall_cycles = 0;
    int fault_count = 0;

    url_query_string_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .uri_byte   (uri_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .part       (part),
        .pair_end   (pair_end),
        .bad_escape (bad_escape),
        .uri_end    (uri_end)
    );

    always #2 clk = ~clk;

    function automatic logic hex_value_of(input logic [7:0] c, output logic [3:0] v);
        logic       ok;
        logic [7:0] d;
        ok = 1'b1;
        d = 8'd0;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
        end
        else
        begin
            ok = 1'b0;
        end
        v = d[3:0];
        return ok;
    endfunction

    function automatic result_t decode_byte(input logic [7:0] b, input logic last);
        result_t    r;
        logic [1:0] sec;
        logic [1:0] ph;
        logic [3:0] digit;
        logic       delim;
        sec = section_q;
        ph = phase_q;
        r = '0;
        r.uri_end = last;
        delim = (b == CH_AMP) || (b == CH_SEMI);
        if (sec == SEC_PATH)
        begin
            r.part = PART_PATH;
        end
        else if (sec == SEC_VALUE)
        begin
            r.part = PART_VALUE;
        end
        else
        begin
            r.part = PART_KEY;
        end
        if (ph == PH_STRAY)
        begin
            ph = PH_NONE;
        end
        case (sec)
            SEC_PATH:
            begin
                if (b == CH_QUERY)
                begin
                    sec = SEC_FRESH;
                end
                else
                begin
                    r.out_byte = b;
                    r.byte_valid = 1'b1;
                end
            end
            SEC_KEY, SEC_FRESH:
            begin
                ph = PH_NONE;
                if (delim)
                begin
                    r.pair_end = 1'b1;
                    sec = SEC_FRESH;
                end
                else if (b == CH_EQ)
                begin
                    sec = SEC_VALUE;
                end
                else
                begin
                    r.out_byte = b;
                    r.byte_valid = 1'b1;
                    sec = SEC_KEY;
                end
            end
            default:
            begin
                if (delim)
                begin
                    r.bad_escape = (ph != PH_NONE);
                    ph = PH_NONE;
                    r.pair_end = 1'b1;
                    sec = SEC_FRESH;
                end
                else if (ph == PH_HIGH)
                begin
                    if (hex_value_of(b, digit))
                    begin
                        nibble_q = digit;
                        ph = PH_LOW;
                    end
                    else
                    begin
                        r.bad_escape = 1'b1;
                        ph = PH_NONE;
                    end
                end
                else if (ph == PH_LOW)
                begin
                    if (hex_value_of(b, digit))
                    begin
                        r.out_byte = {nibble_q, digit};
                        r.byte_valid = 1'b1;
                    end
                    else
                    begin
                        r.bad_escape = 1'b1;
                    end
                    ph = PH_NONE;
                end
                else if (b == CH_PLUS)
                begin
                    r.out_byte = CH_SPACE;
                    r.byte_valid = 1'b1;
                end
                else if (b == CH_PCT)
                begin
                    ph = PH_HIGH;
                end
                else
                begin
                    r.out_byte = b;
                    r.byte_valid = 1'b1;
                end
            end
        endcase
        if (last)
        begin
            if (ph != PH_NONE)
            begin
                r.bad_escape = 1'b1;
            end
            if (sec == SEC_KEY || sec == SEC_VALUE)
            begin
                r.pair_end = 1'b1;
            end
            sec = SEC_PATH;
            ph = PH_NONE;
            nibble_q = 4'd0;
        end
        section_q = sec;
        phase_q = ph;
        return r;
    endfunction

    // predict on input transfer, then check the output transfer
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && in_valid && in_stall)
        begin
            input_stall_cycles++;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            pending_decodes.insert(pending_decodes.size(), decode_byte(uri_byte, is_last));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.out_byte = out_byte;
            got.byte_valid = byte_valid;
            got.part = part;
            got.pair_end = pair_end;
            got.bad_escape = bad_escape;
            got.uri_end = uri_end;
            results_checked++;
            bad_escapes_seen += int'(got.bad_escape);
            pair_ends_seen += int'(got.pair_end);
            if (pending_decodes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                begin
                    $display("unexpected transfer at %0t: byte %h valid %b part %0d", $realtime,
                             got.out_byte, got.byte_valid, got.part);
                end
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.part !== want.part || got.pair_end !== want.pair_end ||
                    got.bad_escape !== want.bad_escape || got.uri_end !== want.uri_end)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display({"mismatch at %0t: expected %h/%b/%0d/%b/%b/%b",
                                  " got %h/%b/%0d/%b/%b/%b"},
                                 $realtime, want.out_byte, want.byte_valid, want.part,
                                 want.pair_end, want.bad_escape, want.uri_end,
                                 got.out_byte, got.byte_valid, got.part,
                                 got.pair_end, got.bad_escape, got.uri_end);
                    end
                end
            end
        end
    end

    // receiver side: long hold-off when requested, random stall otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        uri_byte = b;
        is_last = last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        bytes_sent++;
        uris_sent += int'(last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_uri_buf();
        for (int i = 0; i < uri_buf.size(); i++)
        begin
            send_byte(uri_buf[i], i == uri_buf.size() - 1);
        end
    endtask

    task automatic append_byte(input logic [7:0] c);
        uri_buf.insert(uri_buf.size(), c);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return "0" + v;
        end
        else if ($urandom_range(1) == 1)
        begin
            return "A" + v - 8'd10;
        end
        return "a" + v - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        case ($urandom_range(5))
            0: c = CH_PLUS;
            1: c = CH_PCT;
            2: c = "-";
            3: c = CH_SPACE;
            default:
            begin
                c = 8'($urandom_range(255));
                while (hex_value_of(c, v))
                begin
                    c = 8'($urandom_range(255));
                end
            end
        endcase
        return c;
    endfunction

    // any byte, mostly with '&', ';', '=', '%', '+' and '?' swapped for a letter
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if ($urandom_range(7) != 0)
        begin
            case (c)
                CH_AMP, CH_SEMI, CH_EQ, CH_PCT, CH_PLUS, CH_QUERY:
                begin
                    c = 8'("a" + $urandom_range(25));
                end
                default:
                begin
                end
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] pair_delim();
        return ($urandom_range(1) == 1) ? CH_AMP : CH_SEMI;
    endfunction

    task automatic build_uri();
        int kind;
        int npairs;
        kind = $urandom_range(9);
        uri_buf.delete();
        if (kind == 0)
        begin
            repeat ($urandom_range(12, 1)) append_byte(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(4)) append_byte(plain_char());
            if (kind != 1)
            begin
                append_byte(CH_QUERY);
                npairs = $urandom_range(4);
                for (int p = 0; p < npairs; p++)
                begin
                    if (p > 0)
                    begin
                        append_byte(pair_delim());
                    end
                    repeat ($urandom_range(3)) append_byte(plain_char());
                    if ($urandom_range(4) != 0)
                    begin
                        append_byte(CH_EQ);
                        repeat ($urandom_range(5))
                        begin
                            case ($urandom_range(5))
                                2: append_byte(CH_PLUS);
                                3:
                                begin
                                    append_byte(CH_PCT);
                                    append_byte(hex_char(4'($urandom_range(15))));
                                    append_byte(hex_char(4'($urandom_range(15))));
                                end
                                4:
                                begin
                                    append_byte(CH_PCT);
                                    append_byte(non_hex_char());
                                end
                                5:
                                begin
                                    append_byte(CH_PCT);
                                    append_byte(hex_char(4'($urandom_range(15))));
                                    append_byte(non_hex_char());
                                end
                                default: append_byte(plain_char());
                            endcase
                        end
                    end
                end
                // escape cut short by the end of the uri or by a trailing delimiter
                if ($urandom_range(7) == 0)
                begin
                    append_byte(CH_PCT);
                    if ($urandom_range(1) == 1)
                    begin
                        append_byte(hex_char(4'($urandom_range(15))));
                    end
                end
                if ($urandom_range(5) == 0)
                begin
                    append_byte(pair_delim());
                end
            end
            if (uri_buf.size() == 0)
            begin
                append_byte(plain_char());
            end
        end
    endtask

    // byte extremes in the path, plus sign, escape, later '?' and '=' in a value
    task automatic test_path_and_value_decoding();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("?k=+%4a=?");
    endtask

    // empty pair, pair without '=', delimiter inside an escape, trailing delimiter
    task automatic test_pair_boundaries();
        send_text("?&x;y=%A&");
    endtask

    // empty key, non-hex digit, escape cut short at the end, bare '?'
    task automatic test_escape_faults();
        send_text("?=%G%f");
        send_text("?");
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_input_backpressure();
        int start_count;
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_left = 150;
        start_count = bytes_sent;
        while (bytes_sent - start_count < 40)
        begin
            build_uri();
            send_uri_buf();
        end
    endtask

    task automatic test_random_uris(input int target, input int in_pct, input int out_pct);
        int start_count;
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
        start_count = bytes_sent;
        while (bytes_sent - start_count < target)
        begin
            build_uri();
            send_uri_buf();
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        in_valid = 1'b0;
        out_stall_pct = 0;
        while (pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        $display("sent %0d bytes in %0d uris, checked %0d results", bytes_sent, uris_sent,
                 results_checked);
        $display("saw %0d pair ends, %0d bad escapes, %0d cycles of input stall",
                 pair_ends_seen, bad_escapes_seen, input_stall_cycles);
        if (fault_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_path_and_value_decoding();
        test_pair_boundaries();
        test_escape_faults();
        test_input_backpressure();
        test_random_uris(375, 0, 0);
        test_random_uris(375, 71, 0);
        test_random_uris(375, 0, 71);
        test_random_uris(375, 24, 24);
        finish_run();
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[url_query_string_decoder.f]
sv/uqsd_pkg.sv
sv/uqsd_step.sv
sv/url_query_string_decoder.sv
bench/tb_top.sv
